// ===== hdl/cfnp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfnp_pkg: shared types and character codes for the cell file name parser
// Holds the per-beat step control and the ASCII codes of the name form.
// ----------------------------------------------------------------------------
package cfnp_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
  localparam logic [7:0] CH_US    = 8'h5F;  // '_'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // One character step handed from the input stage to the parser.
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] char_code;
  } cfnp_step_t;

endpackage : cfnp_pkg
`default_nettype wire

// ===== hdl/cell_file_name_parser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cell_file_name_parser_core: streaming cell_X_Y.xml path name checker
// Flow: a beat is registered in the input stage, then parsed; out_valid
//   rises once the final beat leaves the input stage into the result register.
// Throughput: one character beat per cycle; a final beat waits in the input
//   register only while the previous result beat is still held.
// Reset: synchronous, clears both stages and the parser to a fresh path.
// ----------------------------------------------------------------------------
module cell_file_name_parser_core
  import cfnp_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int MIN_LENGTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_char_code,
  input  wire logic                  in_final_char,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_is_match,
  output logic      [COORD_BITS-1:0] out_cell_x,
  output logic      [COORD_BITS-1:0] out_cell_y
);

  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_last_r;
  logic                  s1_fire;
  cfnp_step_t            step;

  logic                  match_ok;
  logic [COORD_BITS-1:0] x_val;
  logic [COORD_BITS-1:0] y_val;

  logic                  out_valid_r;
  logic                  out_match_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;

  // Only a final beat needs the result slot; others advance freely.
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_final_char;
    end
  end

  assign step.fire      = s1_fire;
  assign step.last      = s1_last_r;
  assign step.char_code = s1_char_r;

  cfnp_parser #(
    .COORD_BITS(COORD_BITS),
    .MIN_LENGTH(MIN_LENGTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .match_ok(match_ok),
    .x_val   (x_val),
    .y_val   (y_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_match_r <= match_ok;
      out_x_r     <= match_ok ? x_val : '0;
      out_y_r     <= match_ok ? y_val : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_match = out_match_r;
  assign out_cell_x   = out_x_r;
  assign out_cell_y   = out_y_r;

  a_empty_takes_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("final beat produced no result");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_match_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("coordinates nonzero on a failed match");

  a_middle_beat_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_last_r && !out_valid_r) |=> !out_valid_r)
    else $error("result raised by a non-final beat");

endmodule : cell_file_name_parser_core
`default_nettype wire

// ===== hdl/cfnp_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfnp_acc: saturating decimal digit accumulator
// Computes acc * 10 + digit, clamped at the top of the coordinate range.
// ----------------------------------------------------------------------------
module cfnp_acc #(
  parameter int COORD_BITS = 16
) (
  input  wire logic [COORD_BITS-1:0] acc_in,
  input  wire logic [3:0]            digit,
  output logic      [COORD_BITS-1:0] acc_out
);

  localparam int WIDE_BITS = COORD_BITS + 4;

  logic [WIDE_BITS-1:0] acc_wide;
  logic [WIDE_BITS-1:0] sum_wide;

  always_comb begin
    acc_wide = {4'b0000, acc_in};
    // times ten as (x << 3) + (x << 1)
    sum_wide = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_BITS-4){1'b0}}, digit};
    if (sum_wide[WIDE_BITS-1:COORD_BITS] != 4'b0000) begin
      acc_out = {COORD_BITS{1'b1}};
    end else begin
      acc_out = sum_wide[COORD_BITS-1:0];
    end
  end

endmodule : cfnp_acc
`default_nettype wire

// ===== hdl/cfnp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfnp_parser: name form checker with coordinate accumulators
// Advances the phase, length count and X/Y values by one character per step.
// ----------------------------------------------------------------------------
module cfnp_parser
  import cfnp_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int MIN_LENGTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfnp_step_t            step,
  output logic                       match_ok,
  output logic      [COORD_BITS-1:0] x_val,
  output logic      [COORD_BITS-1:0] y_val
);

  localparam int LEN_W = $clog2(MIN_LENGTH + 1);
  localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(MIN_LENGTH);

  typedef enum logic [3:0] {
    PH_C, PH_E, PH_L1, PH_L2, PH_US,
    PH_X0, PH_XZ, PH_XN,
    PH_Y0, PH_YZ, PH_YN,
    PH_DX, PH_DM, PH_DL, PH_OK, PH_FAIL
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;

  logic [7:0]            c;
  logic                  is_digit;
  logic [3:0]            digit;
  logic                  on_x;
  logic [COORD_BITS-1:0] acc_in;
  logic [COORD_BITS-1:0] acc_out;

  assign c = step.char_code;

  always_comb begin
    is_digit = c inside {[CH_ZERO:CH_NINE]};
  end

  assign digit  = 4'(c - CH_ZERO);
  assign on_x   = (phase_r == PH_X0) || (phase_r == PH_XN);
  assign acc_in = on_x ? x_r : y_r;

  // One shared accumulator: only one coordinate takes a digit per beat.
  cfnp_acc #(
    .COORD_BITS(COORD_BITS)
  ) u_acc (
    .acc_in (acc_in),
    .digit  (digit),
    .acc_out(acc_out)
  );

  always_comb begin
    phase_nxt = phase_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    len_nxt   = (len_r < LEN_TOP) ? len_r + 1'b1 : len_r;

    if (c == CH_SLASH) begin
      phase_nxt = PH_C;
      x_nxt     = '0;
      y_nxt     = '0;
    end else begin
      case (phase_r)
        PH_C:  phase_nxt = (c == CH_C)  ? PH_E  : PH_FAIL;
        PH_E:  phase_nxt = (c == CH_E)  ? PH_L1 : PH_FAIL;
        PH_L1: phase_nxt = (c == CH_L)  ? PH_L2 : PH_FAIL;
        PH_L2: phase_nxt = (c == CH_L)  ? PH_US : PH_FAIL;
        PH_US: phase_nxt = (c == CH_US) ? PH_X0 : PH_FAIL;
        PH_X0: begin
          if (c == CH_ZERO) begin
            phase_nxt = PH_XZ;
          end else if (is_digit) begin
            x_nxt     = acc_out;
            phase_nxt = PH_XN;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_XZ: phase_nxt = (c == CH_US) ? PH_Y0 : PH_FAIL;
        PH_XN: begin
          if (is_digit) begin
            x_nxt = acc_out;
          end else begin
            phase_nxt = (c == CH_US) ? PH_Y0 : PH_FAIL;
          end
        end
        PH_Y0: begin
          if (c == CH_ZERO) begin
            phase_nxt = PH_YZ;
          end else if (is_digit) begin
            y_nxt     = acc_out;
            phase_nxt = PH_YN;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_YZ: phase_nxt = (c == CH_DOT) ? PH_DX : PH_FAIL;
        PH_YN: begin
          if (is_digit) begin
            y_nxt = acc_out;
          end else begin
            phase_nxt = (c == CH_DOT) ? PH_DX : PH_FAIL;
          end
        end
        PH_DX: phase_nxt = (c == CH_X) ? PH_DM : PH_FAIL;
        PH_DM: phase_nxt = (c == CH_M) ? PH_DL : PH_FAIL;
        PH_DL: phase_nxt = (c == CH_L) ? PH_OK : PH_FAIL;
        PH_OK: phase_nxt = PH_OK;
        default: phase_nxt = PH_FAIL;
      endcase
    end
  end

  assign match_ok = (phase_nxt == PH_OK) && (len_nxt == LEN_TOP);
  assign x_val    = x_nxt;
  assign y_val    = y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_C;
      x_r     <= '0;
      y_r     <= '0;
      len_r   <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        // drop everything back to the start of a new path
        phase_r <= PH_C;
        x_r     <= '0;
        y_r     <= '0;
        len_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        len_r   <= len_nxt;
      end
    end
  end

endmodule : cfnp_parser
`default_nettype wire

// ===== tb/cfnp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfnp_checker: result predictor and scoreboard for the cell file name parser
// Watches both channels, tracks the name form on every accepted character
// beat, queues the expected match result on each final beat and compares
// every accepted result beat against the oldest queued one.
// ----------------------------------------------------------------------------
module cfnp_checker #(
  parameter int COORD_BITS = 16,
  parameter int MIN_LENGTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [7:0]            in_char_code,
  input  wire logic                  in_final_char,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  out_is_match,
  input  wire logic [COORD_BITS-1:0] out_cell_x,
  input  wire logic [COORD_BITS-1:0] out_cell_y,
  output int                         fail_count,
  output int                         results_owed
);

  typedef enum logic [3:0] {
    WANT_C, WANT_E, WANT_L1, WANT_L2, WANT_US,
    X_FIRST, X_ZERO, X_MORE,
    Y_FIRST, Y_ZERO, Y_MORE,
    EXT_X, EXT_M, EXT_L,
    NAME_OK, NAME_BAD
  } name_phase_t;

  typedef struct {
    logic                  is_match;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
  } cell_result_t;

  localparam logic [63:0] COORD_TOP = (64'd1 << COORD_BITS) - 64'd1;

  name_phase_t           phase;
  logic [COORD_BITS-1:0] x_acc;
  logic [COORD_BITS-1:0] y_acc;
  logic [3:0]            len_count;
  cell_result_t          match_q[$];
  int                    mismatches = 0;
  int                    owed = 0;

  assign fail_count   = mismatches;
  assign results_owed = owed;

  function automatic logic [COORD_BITS-1:0] add_digit(input logic [COORD_BITS-1:0] acc,
                                                      input logic [7:0] c);
    logic [63:0] v;
    v = 64'(acc) * 64'd10 + 64'(c - "0");
    return (v > COORD_TOP) ? COORD_TOP[COORD_BITS-1:0] : v[COORD_BITS-1:0];
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic name_phase_t want_char(input logic [7:0] c, input logic [7:0] w,
                                            input name_phase_t nxt);
    return (c == w) ? nxt : NAME_BAD;
  endfunction

  function automatic void clear_name();
    phase = WANT_C;
    x_acc = '0;
    y_acc = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    if (c == "/") begin
      clear_name();
      return;
    end
    case (phase)
      WANT_C:  phase = want_char(c, "c", WANT_E);
      WANT_E:  phase = want_char(c, "e", WANT_L1);
      WANT_L1: phase = want_char(c, "l", WANT_L2);
      WANT_L2: phase = want_char(c, "l", WANT_US);
      WANT_US: phase = want_char(c, "_", X_FIRST);
      X_FIRST: begin
        if (c == "0") phase = X_ZERO;
        else if (is_dec(c)) begin
          x_acc = add_digit(x_acc, c);
          phase = X_MORE;
        end else phase = NAME_BAD;
      end
      X_ZERO:  phase = want_char(c, "_", Y_FIRST);
      X_MORE: begin
        if (is_dec(c)) x_acc = add_digit(x_acc, c);
        else phase = want_char(c, "_", Y_FIRST);
      end
      Y_FIRST: begin
        if (c == "0") phase = Y_ZERO;
        else if (is_dec(c)) begin
          y_acc = add_digit(y_acc, c);
          phase = Y_MORE;
        end else phase = NAME_BAD;
      end
      Y_ZERO:  phase = want_char(c, ".", EXT_X);
      Y_MORE: begin
        if (is_dec(c)) y_acc = add_digit(y_acc, c);
        else phase = want_char(c, ".", EXT_X);
      end
      EXT_X:   phase = want_char(c, "x", EXT_M);
      EXT_M:   phase = want_char(c, "m", EXT_L);
      EXT_L:   phase = want_char(c, "l", NAME_OK);
      NAME_OK: phase = NAME_OK;  // trailing bytes are ignored
      default: phase = NAME_BAD;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    cell_result_t want;
    if (!rst_n) begin
      clear_name();
      len_count = '0;
    end else begin
      if (in_valid && in_ready) begin
        if (len_count < MIN_LENGTH) len_count = len_count + 4'd1;
        parse_char(in_char_code);
        if (in_final_char) begin
          want.is_match = (phase == NAME_OK) && (len_count >= MIN_LENGTH);
          want.cell_x   = want.is_match ? x_acc : '0;
          want.cell_y   = want.is_match ? y_acc : '0;
          match_q = {match_q, want};
          owed = owed + 1;
          // a new path starts from scratch
          clear_name();
          len_count = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          $error("result beat with no final character pending: is_match %0d x %0d y %0d",
                 out_is_match, out_cell_x, out_cell_y);
          mismatches = mismatches + 1;
        end else begin
          want = match_q.pop_front();
          owed = owed - 1;
          if (out_is_match !== want.is_match) begin
            $error("is_match: expected %0d, actual %0d", want.is_match, out_is_match);
            mismatches = mismatches + 1;
          end
          if (out_cell_x !== want.cell_x) begin
            $error("cell_x: expected %0d, actual %0d", want.cell_x, out_cell_x);
            mismatches = mismatches + 1;
          end
          if (out_cell_y !== want.cell_y) begin
            $error("cell_y: expected %0d, actual %0d", want.cell_y, out_cell_y);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

endmodule : cfnp_checker

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the cell file name parser core
// Streams directed and random paths one character beat at a time with
// random idling on both channels; the checker beside the core predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COORD_BITS = 16;
  localparam int MIN_LENGTH = 12;
  localparam int RANDOM_BEATS = 540;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_char_code;
  logic                  in_final_char;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_is_match;
  logic [COORD_BITS-1:0] out_cell_x;
  logic [COORD_BITS-1:0] out_cell_y;
  int                    fail_count;
  int                    results_owed;

  int                    send_idle;
  int                    recv_idle;
  int                    beats_sent;
  logic [7:0]            path_q[$];

  string directed_paths [12] = '{
    "cell_0_5.xml", "cell_0_5.xm", "dir/cell_12_345.xml", "cell_65535_99999.xml",
    "cell_999999_7.xml", "cell_7_0.xml/", "cell_3_41.xmlabc", "cell_00_1.xml",
    "cell_1_02.xml", "cell_x_1.xml", "c", "a/b/cell_9_9.xml"
  };

  cell_file_name_parser_core #(
    .COORD_BITS(COORD_BITS),
    .MIN_LENGTH(MIN_LENGTH)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_final_char(in_final_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_match (out_is_match),
    .out_cell_x   (out_cell_x),
    .out_cell_y   (out_cell_y)
  );

  cfnp_checker #(
    .COORD_BITS(COORD_BITS),
    .MIN_LENGTH(MIN_LENGTH)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_final_char(in_final_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_match (out_is_match),
    .out_cell_x   (out_cell_x),
    .out_cell_y   (out_cell_y),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: drop ready at random per cycle
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Entered and left at a falling edge; valid holds until the beat is taken.
  task automatic send_beat(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_char_code  = c;
    in_final_char = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent = beats_sent + 1;
    @(negedge clk);
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_beat(path_q[i], i == path_q.size() - 1);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    path_q = {path_q, b};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] any_but_slash();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == "/") ? "z" : c;
  endfunction

  function automatic void add_number();
    int sel;
    int ndig;
    sel = $urandom_range(99);
    if (sel < 15) begin
      add_byte("0");
    end else begin
      // mostly short values, a few long enough to saturate
      ndig = (sel < 85) ? $urandom_range(1, 5) : $urandom_range(6, 8);
      if (sel >= 95) add_byte("0");
      add_byte(8'("0" + $urandom_range(1, 9)));
      for (int i = 1; i < ndig; i++) add_byte(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void build_random_path();
    int kind;
    int n;
    kind = $urandom_range(99);
    path_q.delete();
    if (kind < 88) begin
      n = $urandom_range(0, 2);
      for (int d = 0; d < n; d++) begin
        if ($urandom_range(9) == 0) add_text("cell_1_1.xml");
        else for (int i = 0; i < $urandom_range(1, 5); i++)
          add_byte(8'("a" + $urandom_range(0, 25)));
        add_byte("/");
      end
      add_text("cell_");
      add_number();
      add_byte("_");
      add_number();
      add_text(".xml");
      if ($urandom_range(4) == 0)
        for (int i = 0; i < $urandom_range(1, 3); i++) add_byte(any_but_slash());
      if (kind >= 70) begin
        // break a well-formed name: overwrite one byte or cut it short
        if ($urandom_range(2) == 0) begin
          n = $urandom_range(1, path_q.size());
          path_q = path_q[0:n-1];
        end else begin
          path_q[$urandom_range(path_q.size() - 1)] = 8'($urandom_range(255));
        end
      end
    end else begin
      for (int i = 0; i < $urandom_range(1, 16); i++)
        add_byte(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = '0;
    in_final_char = 1'b0;
    send_idle     = 10;
    recv_idle     = 72;
    beats_sent    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_paths[k]) begin
      path_q.delete();
      add_text(directed_paths[k]);
      send_path();
    end
    path_q.delete();
    add_byte(8'hFF);
    add_byte(8'h00);
    send_path();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent < RANDOM_BEATS / 3) begin
        send_idle = 10;
        recv_idle = 72;
      end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
        send_idle = 72;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      build_random_path();
      send_path();
    end
    in_valid = 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_top
